// File: sv/pidod_pkg.sv
// ----------------------------------------------------------------------------
// pidod_pkg
// Shared constants, types and helpers for the PID controller with output
// delay: register indexes, reset values, field widths and 32-bit saturation.
// ----------------------------------------------------------------------------
package pidod_pkg;

  // Delay line depth and derived widths
  localparam int MAX_DELAY = 64;
  localparam int RING_AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int FILL_W    = $clog2(MAX_DELAY + 1);

  // Field widths
  localparam int MEAS_W  = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int GAIN_W  = 24;
  localparam int DLY_W   = 7;
  localparam int CTL_W   = 32;
  localparam int PROD_W  = 42;
  localparam int DPROD_W = 43;
  localparam int SAT_W   = 43;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 24;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_SET_POINT  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_DELAY_LEN  = 3'd4;

  // Register reset values
  localparam logic signed [MEAS_W-1:0] RST_SET_POINT  = 16'sd1728;
  localparam logic [GAIN_W-1:0]        RST_PROP_GAIN  = 24'd2458;
  localparam logic [GAIN_W-1:0]        RST_INTEG_GAIN = 24'd82;
  localparam logic [GAIN_W-1:0]        RST_DERIV_GAIN = 24'd819;
  localparam logic [DLY_W-1:0]         RST_DELAY_LEN  = 7'd5;

  // Saturated value with its overflow flag
  typedef struct packed {
    logic signed [CTL_W-1:0] val;
    logic                    hit;
  } sat_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if ((&v[SAT_W-1:CTL_W-1]) || !(|v[SAT_W-1:CTL_W-1])) begin
      r.val = v[CTL_W-1:0];
      r.hit = 1'b0;
    end else begin
      r.val = v[SAT_W-1] ? {1'b1, {(CTL_W-1){1'b0}}} : {1'b0, {(CTL_W-1){1'b1}}};
      r.hit = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: sv/pidod_ram.sv
// ----------------------------------------------------------------------------
// pidod_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, read-first output that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pidod_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read; a read of the entry being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/pid_controller_with_output_delay.sv
// ----------------------------------------------------------------------------
// pid_controller_with_output_delay
// Fixed-point PID controller with a transport delay line on its output.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output is not stalled and returns
// one result per item in order. The pipeline is: error, three gain multiplies,
// integral and derivative update, P+I+D sum with saturation, then the delay
// line access into the output register. The delay line is one RAM of MAX_DELAY
// words that takes one read and one write per cycle; that port pair sets the
// rate of one item per cycle. Integral and held derivative update in one add
// and clamp per item, so they also allow one item per cycle. Each stage holds
// its item until the next stage is free, so bubbles collapse while the output
// waits.
// ----------------------------------------------------------------------------
module pid_controller_with_output_delay (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pidod_pkg::MEAS_W-1:0]   in_measurement,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pidod_pkg::CTL_W-1:0]    out_control,
  output logic                                  out_saturated,
  output logic                                  out_from_delay_line,
  input  logic                                  cfg_we,
  input  logic [pidod_pkg::CFG_AW-1:0]          cfg_index,
  input  logic [pidod_pkg::CFG_DW-1:0]          cfg_wdata
);

  localparam int ERR_W   = pidod_pkg::ERR_W;
  localparam int GAIN_W  = pidod_pkg::GAIN_W;
  localparam int CTL_W   = pidod_pkg::CTL_W;
  localparam int SAT_W   = pidod_pkg::SAT_W;
  localparam int FILL_W  = pidod_pkg::FILL_W;
  localparam int RING_AW = pidod_pkg::RING_AW;
  localparam int MAXD    = pidod_pkg::MAX_DELAY;

  // ---------------- configuration registers ----------------
  logic signed [pidod_pkg::MEAS_W-1:0] sp_r;
  logic [GAIN_W-1:0]                   kp_r, ki_r, kd_r;
  logic [pidod_pkg::DLY_W-1:0]         dly_len_r;

  // Write registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= pidod_pkg::RST_SET_POINT;
      kp_r      <= pidod_pkg::RST_PROP_GAIN;
      ki_r      <= pidod_pkg::RST_INTEG_GAIN;
      kd_r      <= pidod_pkg::RST_DERIV_GAIN;
      dly_len_r <= pidod_pkg::RST_DELAY_LEN;
    end else if (cfg_we) begin
      case (cfg_index)
        pidod_pkg::CFG_SET_POINT:  sp_r      <= cfg_wdata[pidod_pkg::MEAS_W-1:0];
        pidod_pkg::CFG_PROP_GAIN:  kp_r      <= cfg_wdata[GAIN_W-1:0];
        pidod_pkg::CFG_INTEG_GAIN: ki_r      <= cfg_wdata[GAIN_W-1:0];
        pidod_pkg::CFG_DERIV_GAIN: kd_r      <= cfg_wdata[GAIN_W-1:0];
        pidod_pkg::CFG_DELAY_LEN:  dly_len_r <= cfg_wdata[pidod_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage valids and flow control ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic r1, r2, r3, r4, r5;

  assign r5 = !v5_r || out_ready;
  assign r4 = !v4_r || r5;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;

  assign in_ready = r1;

  // Advance valids wherever the stage can take its input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
    end
  end

  logic mv1, mv2, mv4;
  assign mv1 = v1_r && r2;
  assign mv2 = v2_r && r3;
  assign mv4 = v4_r && r5;

  // ---------------- stage 1: error ----------------
  logic signed [ERR_W-1:0] err1_r;

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      err1_r <= ERR_W'(sp_r) - ERR_W'(in_measurement);
    end
  end

  // ---------------- stage 2: gain products ----------------
  logic signed [ERR_W-1:0]              prev_err_r;
  logic                                 prev_valid_r;
  logic signed [GAIN_W:0]               kp_s, ki_s, kd_s;
  logic signed [pidod_pkg::DIFF_W-1:0]  diff;
  logic signed [pidod_pkg::PROD_W-1:0]  p_prod, i_prod;
  logic signed [pidod_pkg::DPROD_W-1:0] d_prod;
  logic signed [pidod_pkg::PROD_W-1:0]  p2_r, i2_r;
  logic signed [pidod_pkg::DPROD_W-1:0] d2_r;
  logic                                 dval2_r;

  assign kp_s   = $signed({1'b0, kp_r});
  assign ki_s   = $signed({1'b0, ki_r});
  assign kd_s   = $signed({1'b0, kd_r});
  assign diff   = pidod_pkg::DIFF_W'(err1_r) - pidod_pkg::DIFF_W'(prev_err_r);
  assign p_prod = err1_r * kp_s;
  assign i_prod = err1_r * ki_s;
  assign d_prod = diff * kd_s;

  // Hold the previous error for the derivative
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r   <= '0;
      prev_valid_r <= 1'b0;
    end else if (mv1) begin
      prev_err_r   <= err1_r;
      prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      p2_r    <= p_prod;
      i2_r    <= i_prod;
      d2_r    <= d_prod;
      dval2_r <= prev_valid_r;
    end
  end

  // ---------------- stage 3: integral and derivative ----------------
  logic signed [CTL_W-1:0]              integ_acc_r, deriv_hold_r;
  logic signed [SAT_W-1:0]              i_sum;
  pidod_pkg::sat_t                      i_sat, d_sat;
  logic signed [CTL_W-1:0]              deriv_nxt;
  logic                                 hit3_nxt;
  logic signed [pidod_pkg::PROD_W-1:0]  p3_r;
  logic signed [CTL_W-1:0]              i3_r, d3_r;
  logic                                 hit3_r;

  assign i_sum     = SAT_W'(integ_acc_r) + SAT_W'(i2_r);
  assign i_sat     = pidod_pkg::sat32(i_sum);
  assign d_sat     = pidod_pkg::sat32(SAT_W'(d2_r));
  assign deriv_nxt = dval2_r ? d_sat.val : deriv_hold_r;
  assign hit3_nxt  = i_sat.hit || (dval2_r && d_sat.hit);

  // Update the integral and held derivative once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r  <= '0;
      deriv_hold_r <= '0;
    end else if (mv2) begin
      integ_acc_r  <= i_sat.val;
      deriv_hold_r <= deriv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      p3_r   <= p2_r;
      i3_r   <= i_sat.val;
      d3_r   <= deriv_nxt;
      hit3_r <= hit3_nxt;
    end
  end

  // ---------------- stage 4: sum ----------------
  logic signed [SAT_W-1:0] pid_sum;
  pidod_pkg::sat_t         ctl_sat;
  logic signed [CTL_W-1:0] ctl4_r;
  logic                    hit4_r;

  assign pid_sum = SAT_W'(p3_r) + SAT_W'(i3_r) + SAT_W'(d3_r);
  assign ctl_sat = pidod_pkg::sat32(pid_sum);

  always_ff @(posedge clk) begin
    if (v3_r && r4) begin
      ctl4_r <= ctl_sat.val;
      hit4_r <= hit3_r || ctl_sat.hit;
    end
  end

  // ---------------- stage 5: delay line and output ----------------
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [FILL_W-1:0]  dly_eff;
  logic [FILL_W:0]    waddr_sum;
  logic [RING_AW-1:0] ring_waddr;
  logic               ring_we, ring_re, do_fill, do_shift;
  logic [CTL_W-1:0]   ring_rdata;
  logic signed [CTL_W-1:0] ctl5_r;
  logic               hit5_r, dly5_r;

  assign dly_eff   = (32'(dly_len_r) > 32'(MAXD)) ? FILL_W'(MAXD) : FILL_W'(dly_len_r);
  assign waddr_sum = (FILL_W+1)'(head_r) + (FILL_W+1)'(fill_r);
  assign ring_waddr = (32'(waddr_sum) >= 32'(MAXD)) ?
                      RING_AW'(waddr_sum - (FILL_W+1)'(MAXD)) : RING_AW'(waddr_sum);

  assign do_fill  = fill_r < dly_eff;
  assign do_shift = !do_fill && (fill_r != '0);
  assign ring_we  = mv4 && (do_fill || do_shift);
  assign ring_re  = mv4 && do_shift;

  // Grow the line while short of the delay, else pop the oldest entry
  always_comb begin
    fill_nxt = fill_r;
    head_nxt = head_r;
    if (mv4 && do_fill) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (mv4 && do_shift) begin
      head_nxt = (32'(head_r) == MAXD - 1) ? '0 : head_r + RING_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      head_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      head_r <= head_nxt;
    end
  end

  // A full line reads and writes the same entry; the RAM returns the old word
  pidod_ram #(
    .WIDTH (CTL_W),
    .DEPTH (MAXD),
    .AW    (RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ctl4_r),
    .re    (ring_re),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (mv4) begin
      ctl5_r <= ctl4_r;
      hit5_r <= hit4_r;
      dly5_r <= do_shift;
    end
  end

  assign out_valid           = v5_r;
  assign out_control         = dly5_r ? $signed(ring_rdata) : ctl5_r;
  assign out_saturated       = hit5_r;
  assign out_from_delay_line = dly5_r;

  // ---------------- assertions ----------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAXD)
    else $error("delay line fill count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < MAXD)
    else $error("delay line head beyond depth");

  a_ring_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !mv4 |=> $stable(fill_r) && $stable(head_r))
    else $error("delay line state moved without a transfer");

  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    ring_re |=> v5_r && dly5_r)
    else $error("ring read not presented as a delayed result");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PID controller with output delay. A directed
// table covers reset behavior, field extremes, saturation of each term,
// unused register indexes and changes of the delay length. Random segments
// with new register settings follow. An in-bench model predicts each result
// unless a directed row gives it, and a monitor checks each output transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  import pidod_pkg::*;

  // One control result as it leaves the block
  typedef struct packed {
    logic signed [CTL_W-1:0] control;
    logic                    saturated;
    logic                    from_delay_line;
  } ctl_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // One row of the directed stimulus table
  typedef struct {
    row_kind_t                kind;
    logic [CFG_AW-1:0]        index;
    logic [CFG_DW-1:0]        wdata;
    logic signed [MEAS_W-1:0] meas;
    bit                       typed;
    ctl_result_t              want;
  } stim_row_t;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  // Longest quiet stretch: the forced output hold-off plus a long random
  // stall, with a wide margin on top
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RAND_SEGMENTS = 15;
  localparam int SEG_ITEMS     = 103;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [MEAS_W-1:0] in_measurement;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [CTL_W-1:0]  out_control;
  logic                     out_saturated;
  logic                     out_from_delay_line;
  logic                     cfg_we;
  logic [CFG_AW-1:0]        cfg_index;
  logic [CFG_DW-1:0]        cfg_wdata;

  // Side information that travels with each sample transfer
  bit          drv_typed;
  ctl_result_t drv_want;

  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  mismatch_cnt = 0;
  int  idle_cnt = 0;

  ctl_result_t pending_controls[$];
  stim_row_t   directed_rows[$];

  // Controller model: configuration copy
  logic signed [MEAS_W-1:0] sp_r  = RST_SET_POINT;
  logic [GAIN_W-1:0]        kp_r  = RST_PROP_GAIN;
  logic [GAIN_W-1:0]        ki_r  = RST_INTEG_GAIN;
  logic [GAIN_W-1:0]        kd_r  = RST_DERIV_GAIN;
  logic [DLY_W-1:0]         dly_r = RST_DELAY_LEN;

  // Controller model: state
  logic signed [CTL_W-1:0]  integ_acc   = '0;
  logic signed [CTL_W-1:0]  deriv_term  = '0;
  logic signed [ERR_W-1:0]  last_err    = '0;
  bit                       last_err_ok = 1'b0;
  logic [CTL_W-1:0]         delay_mem [MAX_DELAY];
  int                       fill_cnt    = 0;
  int                       head_ptr    = 0;

  pid_controller_with_output_delay uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_measurement      (in_measurement),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_control         (out_control),
    .out_saturated       (out_saturated),
    .out_from_delay_line (out_from_delay_line),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit range and flag a clamp
  function automatic longint clamp32(input longint v, inout bit hit);
    if (v > S32_HI) begin
      hit = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      hit = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  // Advance the controller model by one sample and return its result
  function automatic ctl_result_t predict_control(input logic signed [MEAS_W-1:0] meas);
    ctl_result_t r;
    longint      err;
    longint      acc;
    longint      dterm;
    longint      sum;
    logic [CTL_W-1:0] oldest;
    int          lim;
    bit          hit;
    hit = 1'b0;
    err = longint'(sp_r) - longint'(meas);
    acc = clamp32(longint'(integ_acc) + err * longint'(ki_r), hit);
    integ_acc = acc[CTL_W-1:0];
    // Hold the derivative term until a previous error exists
    if (last_err_ok) begin
      dterm = clamp32((err - longint'(last_err)) * longint'(kd_r), hit);
      deriv_term = dterm[CTL_W-1:0];
    end
    last_err    = err[ERR_W-1:0];
    last_err_ok = 1'b1;
    sum = err * longint'(kp_r) + longint'(integ_acc) + longint'(deriv_term);
    r.control         = 32'(clamp32(sum, hit));
    r.saturated       = hit;
    r.from_delay_line = 1'b0;
    lim = (int'(dly_r) > MAX_DELAY) ? MAX_DELAY : int'(dly_r);
    // Fill the line first, then pop one entry per push
    if (fill_cnt < lim) begin
      delay_mem[(head_ptr + fill_cnt) % MAX_DELAY] = r.control;
      fill_cnt++;
    end else if (fill_cnt > 0) begin
      oldest = delay_mem[head_ptr];
      delay_mem[(head_ptr + fill_cnt) % MAX_DELAY] = r.control;
      head_ptr = (head_ptr + 1) % MAX_DELAY;
      r.control         = oldest;
      r.from_delay_line = 1'b1;
    end
    return r;
  endfunction

  // Monitor: check results, predict on input transfers, track register writes
  always @(posedge clk) begin
    ctl_result_t exp_res;
    ctl_result_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_controls.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with nothing pending: control=%0d sat=%0b dly=%0b",
                   $time, out_control, out_saturated, out_from_delay_line);
        end else begin
          exp_res = pending_controls.pop_front();
          if (out_control !== exp_res.control) begin
            mismatch_cnt++;
            $display("%0t: control expected %0d actual %0d",
                     $time, exp_res.control, out_control);
          end
          if (out_saturated !== exp_res.saturated) begin
            mismatch_cnt++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, exp_res.saturated, out_saturated);
          end
          if (out_from_delay_line !== exp_res.from_delay_line) begin
            mismatch_cnt++;
            $display("%0t: from_delay_line expected %0b actual %0b",
                     $time, exp_res.from_delay_line, out_from_delay_line);
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = predict_control(in_measurement);
        if (drv_typed) pred = drv_want;
        pending_controls.insert(pending_controls.size(), pred);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_POINT:  sp_r  = cfg_wdata[MEAS_W-1:0];
          CFG_PROP_GAIN:  kp_r  = cfg_wdata[GAIN_W-1:0];
          CFG_INTEG_GAIN: ki_r  = cfg_wdata[GAIN_W-1:0];
          CFG_DERIV_GAIN: kd_r  = cfg_wdata[GAIN_W-1:0];
          CFG_DELAY_LEN:  dly_r = cfg_wdata[DLY_W-1:0];
          default: ;
        endcase
      end
      // Watchdog on cycles without any transfer
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Wait until every pending result has been seen, return on a rising edge
  task automatic wait_drained();
    do @(negedge clk); while (pending_controls.size() != 0);
    @(posedge clk);
  endtask

  // Write one register once the block is idle
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample after an optional gap and hold it until the transfer
  task automatic send_sample(input logic signed [MEAS_W-1:0] m, input bit typed,
                             input ctl_result_t want);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid       <= 1'b1;
    in_measurement <= m;
    drv_typed      <= typed;
    drv_want       <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, index: idx, wdata: val, meas: '0, typed: 1'b0, want: '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_meas(input logic signed [MEAS_W-1:0] m, input bit typed,
                          input ctl_result_t want);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, index: '0, wdata: '0, meas: m, typed: typed, want: want};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [DLY_W-1:0] pick_delay(input int seg);
    // Force the deep, beyond-depth and zero settings early, random afterwards
    if (seg == 0) return DLY_W'(MAX_DELAY);
    if (seg == 1) return '1;
    if (seg == 2) return '0;
    return DLY_W'($urandom_range(0, 127));
  endfunction

  function automatic logic signed [MEAS_W-1:0] pick_sp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (r < 5) return MEAS_W'($urandom);
    return MEAS_W'($urandom_range(0, 4095)) - 16'sd2048;
  endfunction

  // Most samples sit near the set point, the rest anywhere in range
  function automatic logic signed [MEAS_W-1:0] pick_meas(input logic signed [MEAS_W-1:0] sp);
    int v;
    if ($urandom_range(0, 9) < 6) begin
      v = int'(sp) + int'($urandom_range(0, 1023)) - 512;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[MEAS_W-1:0];
    end
    return MEAS_W'($urandom);
  endfunction

  // Sender: reset, directed table, random segments, end of run
  initial begin
    logic signed [MEAS_W-1:0] seg_sp;
    in_valid       = 1'b0;
    in_measurement = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    drv_typed      = 1'b0;
    drv_want       = '0;
    send_idle      = 23;
    recv_idle      = 55;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Zero delay while the line is still empty: everything passes through
    add_cfg(CFG_DELAY_LEN, '0);
    // At the set point after reset: no error, nothing held
    add_meas(16'sd1728, 1'b1, '{control: '0, saturated: 1'b0, from_delay_line: 1'b0});
    add_meas(16'sd1728, 1'b1, '{control: '0, saturated: 1'b0, from_delay_line: 1'b0});
    add_meas(16'sd0, 1'b0, '0);
    add_meas(16'sh7FFF, 1'b0, '0);
    add_meas(16'sh8000, 1'b0, '0);
    // Largest positive and negative error with full proportional gain
    add_cfg(CFG_PROP_GAIN, '1);
    add_cfg(CFG_SET_POINT, 24'h007FFF);
    add_meas(16'sh8000, 1'b1,
             '{control: 32'h7FFF_FFFF, saturated: 1'b1, from_delay_line: 1'b0});
    add_cfg(CFG_SET_POINT, 24'h008000);
    add_meas(16'sh7FFF, 1'b1,
             '{control: 32'h8000_0000, saturated: 1'b1, from_delay_line: 1'b0});
    // Integral overflow with the proportional term off
    add_cfg(CFG_PROP_GAIN, '0);
    add_cfg(CFG_INTEG_GAIN, '1);
    add_meas(16'sh7FFF, 1'b0, '0);
    add_meas(16'sh7FFF, 1'b0, '0);
    // Derivative overflow on a large error jump
    add_cfg(CFG_INTEG_GAIN, '0);
    add_cfg(CFG_DERIV_GAIN, '1);
    add_cfg(CFG_SET_POINT, '0);
    add_meas(16'sh8000, 1'b0, '0);
    add_meas(16'sh7FFF, 1'b0, '0);
    // Unused register indexes must leave everything unchanged
    for (int i = CFG_DELAY_LEN + 1; i < 2 ** CFG_AW; i++) add_cfg(CFG_AW'(i), '1);
    // Short delay from an empty line, back to the reset gains
    add_cfg(CFG_DELAY_LEN, 24'd3);
    add_cfg(CFG_PROP_GAIN, RST_PROP_GAIN);
    add_cfg(CFG_INTEG_GAIN, RST_INTEG_GAIN);
    add_cfg(CFG_DERIV_GAIN, RST_DERIV_GAIN);
    add_cfg(CFG_SET_POINT, {8'h00, RST_SET_POINT});
    add_meas(16'sd1700, 1'b0, '0);
    add_meas(16'sd1800, 1'b0, '0);
    add_meas(16'sd1650, 1'b0, '0);
    add_meas(16'sd1728, 1'b0, '0);
    add_meas(16'sd1900, 1'b0, '0);
    // Shorten the delay: the extra entries stay in the line
    add_cfg(CFG_DELAY_LEN, 24'd1);
    add_meas(16'sd1600, 1'b0, '0);
    add_meas(16'sd1750, 1'b0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].index, directed_rows[i].wdata);
      end else begin
        send_sample(directed_rows[i].meas, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random segments, each with a fresh register setting
    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      if (seg == 5) begin
        send_idle = 55;
        recv_idle <= 23;
      end
      if (seg == 10) begin
        send_idle = 0;
        recv_idle <= 0;
      end
      seg_sp = pick_sp();
      write_reg(CFG_SET_POINT, {8'($urandom), seg_sp});
      write_reg(CFG_PROP_GAIN, pick_gain());
      write_reg(CFG_INTEG_GAIN, pick_gain());
      write_reg(CFG_DERIV_GAIN, pick_gain());
      write_reg(CFG_DELAY_LEN, {17'($urandom), pick_delay(seg)});
      // Hold off the receiver while the first segment streams in
      if (seg == 0) hold_req <= 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) send_sample(pick_meas(seg_sp), 1'b0, '0);
    end

    // Drain and report
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
